// ===== design/albms_pkg.sv =====
// albms_pkg: shared types and constants for the analog ladder button mode selector
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package albms_pkg;

  // field widths
  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned BUTTON_W = 3;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [BUTTON_W-1:0] button_t;
  typedef logic [MODE_W-1:0]   mode_t;

  // button codes
  localparam button_t BTN_NONE = 3'd0;
  localparam button_t BTN_1    = 3'd1;
  localparam button_t BTN_2    = 3'd2;
  localparam button_t BTN_3    = 3'd3;
  localparam button_t BTN_4    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_LIMIT    = 2'd1;

  // reset values of the limits
  localparam mode_t DISPLAY_LIMIT_RST = 4'd2;
  localparam mode_t FONT_LIMIT_RST    = 4'd1;

  // ladder windows, bounds are exclusive except the button 1 ceiling
  localparam level_t LVL_B1_MAX = 10'd50;
  localparam level_t LVL_B2_LO  = 10'd290;
  localparam level_t LVL_B2_HI  = 10'd315;
  localparam level_t LVL_B3_LO  = 10'd186;
  localparam level_t LVL_B3_HI  = 10'd206;
  localparam level_t LVL_B4_LO  = 10'd86;
  localparam level_t LVL_B4_HI  = 10'd108;

  // one result request
  typedef struct packed {
    button_t accepted_button;
    mode_t   display_mode;
    mode_t   font_mode;
    logic    mode_changed;
  } result_t;

endpackage

// ===== design/albms_if.sv =====
// albms_if: valid/ready channel interfaces for level samples and results
// depends on albms_pkg
`timescale 1ns / 1ps

interface albms_sample_if;
  import albms_pkg::*;

  logic   valid;
  logic   ready;
  level_t button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface albms_result_if;
  import albms_pkg::*;

  logic    valid;
  logic    ready;
  button_t accepted_button;
  mode_t   display_mode;
  mode_t   font_mode;
  logic    mode_changed;

  modport source (output valid, output accepted_button, output display_mode,
                  output font_mode, output mode_changed, input ready);
  modport sink   (input valid, input accepted_button, input display_mode,
                  input font_mode, input mode_changed, output ready);
endinterface

// ===== design/albms_classify.sv =====
// albms_classify: maps a ladder level onto a raw button code through fixed windows
// depends on albms_pkg
`timescale 1ns / 1ps

module albms_classify (
  input  albms_pkg::level_t  level,
  output albms_pkg::button_t raw_button
);
  import albms_pkg::*;

  // window decode, button 1 has priority
  always_comb begin
    if (level inside {[10'd0 : LVL_B1_MAX]}) begin
      raw_button = BTN_1;
    end else if (level inside {[LVL_B2_LO + 10'd1 : LVL_B2_HI - 10'd1]}) begin
      raw_button = BTN_2;
    end else if (level inside {[LVL_B3_LO + 10'd1 : LVL_B3_HI - 10'd1]}) begin
      raw_button = BTN_3;
    end else if (level inside {[LVL_B4_LO + 10'd1 : LVL_B4_HI - 10'd1]}) begin
      raw_button = BTN_4;
    end else begin
      raw_button = BTN_NONE;
    end
  end

endmodule

// ===== design/albms_core.sv =====
// albms_core: debounce counter, accepted button and mode registers, limit registers
// depends on albms_pkg
`timescale 1ns / 1ps

module albms_core #(
  parameter int unsigned DEBOUNCE_SAMPLES = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [albms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [albms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 step,
  input  albms_pkg::button_t                   raw_button,
  output albms_pkg::result_t                   result_next
);
  import albms_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(DEBOUNCE_SAMPLES);

  mode_t            display_limit;
  mode_t            font_limit;
  button_t          stable_button;
  button_t          stable_button_next;
  logic [CNT_W-1:0] debounce_count;
  logic [CNT_W-1:0] debounce_count_next;
  logic [CNT_W-1:0] count_inc;
  mode_t            display_mode;
  mode_t            display_mode_next;
  mode_t            font_mode;
  mode_t            font_mode_next;
  logic             commit;
  logic             press;
  logic             changed;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      display_limit <= DISPLAY_LIMIT_RST;
      font_limit    <= FONT_LIMIT_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_DISPLAY_LIMIT) begin
        display_limit <= mode_t'(cfg_data);
      end
      if (cfg_index == REG_FONT_LIMIT) begin
        font_limit <= mode_t'(cfg_data);
      end
    end
  end

  // debounce: commit once enough differing samples have been seen
  assign count_inc = debounce_count + CNT_W'(1);
  assign commit    = (raw_button != stable_button) && (count_inc >= CNT_DONE);
  assign press     = commit && (stable_button == BTN_NONE);

  always_comb begin
    if (raw_button == stable_button) begin
      debounce_count_next = '0;
    end else if (commit) begin
      debounce_count_next = '0;
    end else begin
      debounce_count_next = count_inc;
    end
    stable_button_next = commit ? raw_button : stable_button;
  end

  // mode stepping on a press edge out of the released state
  always_comb begin
    display_mode_next = display_mode;
    font_mode_next    = font_mode;
    changed           = 1'b0;
    if (press) begin
      case (raw_button)
        BTN_1: begin
          display_mode_next = (display_mode == '0) ? display_limit
                                                   : display_mode - mode_t'(1);
          changed = 1'b1;
        end
        BTN_2: begin
          display_mode_next = (display_mode >= display_limit) ? '0
                                                              : display_mode + mode_t'(1);
          changed = 1'b1;
        end
        BTN_3: begin
          font_mode_next = (font_mode == '0) ? font_limit : font_mode - mode_t'(1);
        end
        BTN_4: begin
          font_mode_next = (font_mode >= font_limit) ? '0 : font_mode + mode_t'(1);
        end
        default: begin
          changed = 1'b0;
        end
      endcase
    end
  end

  // state registers, advanced once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_button  <= BTN_NONE;
      debounce_count <= '0;
      display_mode   <= '0;
      font_mode      <= '0;
    end else if (step) begin
      stable_button  <= stable_button_next;
      debounce_count <= debounce_count_next;
      display_mode   <= display_mode_next;
      font_mode      <= font_mode_next;
    end
  end

  // result of the sample being processed
  always_comb begin
    result_next.accepted_button = stable_button_next;
    result_next.display_mode    = display_mode_next;
    result_next.font_mode       = font_mode_next;
    result_next.mode_changed    = changed;
  end

endmodule

// ===== design/analog_ladder_button_mode_selector.sv =====
// analog_ladder_button_mode_selector: top level with input and result registers
// depends on albms_pkg, albms_if, albms_classify, albms_core
`timescale 1ns / 1ps
//
// Usage
// - samples: one filtered ladder level per request (button_level, 10 bits).
// - results: one request per sample, carrying the debounced button code,
//   the display and font modes after that sample and a mode_changed pulse.
// - cfg_write/cfg_index/cfg_data: index 0 writes the display mode limit,
//   index 1 the font mode limit, other indexes are ignored; write only
//   while no sample is in flight.
// Timing
// - a sample is held in the input register, then decoded, debounced and
//   stepped in one pass into the result register, from which its result
//   is taken.
// - one sample per cycle is sustained while results.ready stays high; the rate is set by the single
//   register-to-register decode and mode step path.
// Reset (rst, synchronous): both stages empty, no button accepted, modes
//   at zero, limits back to 2 (display) and 1 (font).
// Stall: while results.ready is low the result register holds; the input
//   register still takes one more sample if empty, after which samples.ready drops.
//
module analog_ladder_button_mode_selector #(
  parameter int unsigned DEBOUNCE_SAMPLES = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  albms_sample_if.sink                      samples,
  albms_result_if.source                    results,
  input  logic                              cfg_write,
  input  logic [albms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [albms_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import albms_pkg::*;

  logic      in_valid;
  level_t    in_level;
  logic      out_valid;
  result_t   out_result;
  result_t   result_next;
  button_t   raw_button;
  logic      out_free;
  logic      step;

  // handshake: the result register frees up when empty or being taken
  assign out_free      = !out_valid || results.ready;
  assign step          = in_valid && out_free;
  assign samples.ready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      in_level <= samples.button_level;
    end
  end

  albms_classify u_classify (
    .level      (in_level),
    .raw_button (raw_button)
  );

  albms_core #(
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (step),
    .raw_button  (raw_button),
    .result_next (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.accepted_button = out_result.accepted_button;
  assign results.display_mode    = out_result.display_mode;
  assign results.font_mode       = out_result.font_mode;
  assign results.mode_changed    = out_result.mode_changed;

endmodule
